>>> hdl/assert_macros.svh
// Assertion macros shared by the median filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// ante implies cons in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// ante implies cons in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/mf3_pkg.sv
// Shared types and constants of the 3x3 median filter.
package mf3_pkg;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 13;
  localparam int ROW_BITS       = 13;
  localparam int MAX_HEIGHT     = 4096;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // per-request classification made by the front end
  typedef struct packed {
    logic func;      // flush tick
    logic row_zero;  // first input row: replicate into the line stores
    logic has_a;     // interior result for column c-1
    logic a_edge;    // left edge replication for result a
    logic has_b;     // row-end result for the last column
    logic b_single;  // one-pixel rows
    logic last_row;  // row-end result closes the frame
  } mf3_flags_t;

  localparam int FLAGS_BITS = $bits(mf3_flags_t);

endpackage

>>> hdl/mf3_ram.sv
// Generic single-port-write, registered-read RAM.
module mf3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/mf3_front.sv
// Front end: configuration registers, frame position and request classification.
`include "assert_macros.svh"

module mf3_front #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic [mf3_pkg::CFG_INDEX_BITS-1:0]   cfg_index_i,
  input  logic [mf3_pkg::CFG_DATA_BITS-1:0]    cfg_data_i,
  input  logic                                 in_valid_i,
  input  logic                                 func_i,
  input  logic                                 q_ready_i,
  output logic                                 in_ready_o,
  output logic                                 push_o,
  output mf3_pkg::mf3_flags_t                  flags_o,
  output logic [$clog2(MAX_WIDTH)-1:0]         col_o
);

  import mf3_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CW = $clog2(MAX_WIDTH);

  logic [WW-1:0]       width_q, width_d, width_new;
  logic [ROW_BITS-1:0] height_q, height_d, height_new;
  logic [ROW_BITS-1:0] row_q, row_d;
  logic [CW-1:0]       col_q, col_d;
  logic                last_col;
  logic                accept;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && q_ready_i;
  assign push_o     = accept;
  assign col_o      = col_q;

  assign last_col = (WW'(col_q) + WW'(1)) >= width_q;

  always_comb begin
    flags_o.func     = func_i;
    flags_o.row_zero = (row_q == '0);
    flags_o.has_a    = (row_q != '0) && (col_q != '0);
    flags_o.a_edge   = (col_q == CW'(1));
    flags_o.has_b    = (row_q != '0) && last_col;
    flags_o.b_single = (width_q == WW'(1));
    flags_o.last_row = (row_q == height_q);
  end

  // register values are clamped into the supported range
  always_comb begin
    if (cfg_data_i == '0) begin
      width_new = WW'(1);
    end else if (32'(cfg_data_i) > 32'(MAX_WIDTH)) begin
      width_new = WW'(MAX_WIDTH);
    end else begin
      width_new = WW'(cfg_data_i);
    end
    if (cfg_data_i == '0) begin
      height_new = ROW_BITS'(1);
    end else if (32'(cfg_data_i) > 32'(MAX_HEIGHT)) begin
      height_new = ROW_BITS'(MAX_HEIGHT);
    end else begin
      height_new = ROW_BITS'(cfg_data_i);
    end
  end

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    col_d    = col_q;
    row_d    = row_q;
    if (cfg_valid_i && (cfg_index_i == REG_IMAGE_WIDTH ||
                        cfg_index_i == REG_IMAGE_HEIGHT)) begin
      if (cfg_index_i == REG_IMAGE_WIDTH) begin
        width_d = width_new;
      end else begin
        height_d = height_new;
      end
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = (row_q >= height_q) ? '0 : row_q + ROW_BITS'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WW'(1);
      height_q <= ROW_BITS'(1);
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

  `ASSERT_ALWAYS(a_col_in_row, clk_i, rst_ni, WW'(col_q) < width_q, "column beyond row width")
  `ASSERT_ALWAYS(a_row_in_frame, clk_i, rst_ni, row_q <= height_q, "row beyond flush row")

endmodule

>>> hdl/mf3_queue.sv
// Short request queue between front end and back end.
`include "assert_macros.svh"

module mf3_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             ready_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [NW-1:0]    count_q;

  assign ready_o = (count_q != NW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + NW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - NW'(1);
      end
    end
  end

  `ASSERT_IMPLIES(a_no_overflow, clk_i, rst_ni, push_i, count_q != NW'(DEPTH), "queue overflow")
  `ASSERT_IMPLIES(a_no_underflow, clk_i, rst_ni, pop_i, count_q != '0, "queue underflow")

endmodule

>>> hdl/mf3_back.sv
// Back end: line stores, 3x3 window, compare network and result output.
`include "assert_macros.svh"

module mf3_back #(
  parameter int MAX_WIDTH  = 4096,
  parameter int PIXEL_BITS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  output logic                         req_ready_o,
  input  mf3_pkg::mf3_flags_t          req_flags_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] req_col_i,
  input  logic [PIXEL_BITS-1:0]        req_pixel_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [PIXEL_BITS-1:0]        median_out_o,
  output logic                         row_end_o,
  output logic                         frame_end_o
);

  import mf3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  typedef logic [PIXEL_BITS-1:0] pix_t;

  function automatic pix_t min2(pix_t a, pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(pix_t a, pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // stage S1: line store data back, window shift
  logic       s1_v_q;
  mf3_flags_t s1_flags_q;
  logic [CW-1:0] s1_col_q;
  pix_t       s1_pix_q;
  logic       byp_hit_q;
  pix_t       byp_up_q, byp_mid_q;
  pix_t       up_rd, mid_rd, up_rdata, mid_rdata;
  pix_t       cur_s1, up_s1, mid_s1;

  // stage S2: window holds this request's neighbourhood
  logic       s2_v_q;
  mf3_flags_t s2_flags_q;
  pix_t       win_q [9];

  // stage S3: per-row min / median / max for both results
  logic       s3_v_q;
  mf3_flags_t s3_flags_q;
  pix_t       a_min_q [3], a_med_q [3], a_max_q [3];
  pix_t       b_min_q [3], b_med_q [3], b_max_q [3];
  pix_t       a_min_d [3], a_med_d [3], a_max_d [3];
  pix_t       b_min_d [3], b_med_d [3], b_max_d [3];
  pix_t       med_a, med_b;

  // output register plus one pending row-end result
  logic       out_v_q, out_row_end_q, out_frame_end_q;
  pix_t       out_med_q;
  logic       pend_v_q, pend_frame_end_q;
  pix_t       pend_med_q;

  logic pop, s1_adv, s2_adv, s3_adv;
  logic s1_ready, s2_ready, s3_ready, out_take;

  assign out_take = out_v_q && out_ready_i;
  assign s3_ready = !s3_v_q || (!pend_v_q && (!out_v_q || out_take));
  assign s3_adv   = s3_v_q && s3_ready;
  assign s2_ready = !s2_v_q || s3_ready;
  assign s2_adv   = s2_v_q && s2_ready;
  assign s1_ready = !s1_v_q || s2_ready;
  assign s1_adv   = s1_v_q && s2_ready;
  assign pop      = req_valid_i && s1_ready;
  assign req_ready_o = s1_ready;

  mf3_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_upper (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (mid_s1),
    .re_i    (pop),
    .raddr_i (req_col_i),
    .rdata_o (up_rdata)
  );

  mf3_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_middle (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (cur_s1),
    .re_i    (pop),
    .raddr_i (req_col_i),
    .rdata_o (mid_rdata)
  );

  // a write in the read cycle to the same column is forwarded
  always_comb begin
    up_rd  = byp_hit_q ? byp_up_q  : up_rdata;
    mid_rd = byp_hit_q ? byp_mid_q : mid_rdata;
    cur_s1 = s1_flags_q.func ? mid_rd : s1_pix_q;
    up_s1  = s1_flags_q.row_zero ? cur_s1 : up_rd;
    mid_s1 = s1_flags_q.row_zero ? cur_s1 : mid_rd;
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_flags_q <= req_flags_i;
      s1_col_q   <= req_col_i;
      s1_pix_q   <= req_pixel_i;
      byp_up_q   <= mid_s1;
      byp_mid_q  <= cur_s1;
    end
    if (s1_adv) begin
      s2_flags_q <= s1_flags_q;
    end
    if (s2_adv) begin
      s3_flags_q <= s2_flags_q;
      a_min_q <= a_min_d;
      a_med_q <= a_med_d;
      a_max_q <= a_max_d;
      b_min_q <= b_min_d;
      b_med_q <= b_med_d;
      b_max_q <= b_max_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      s3_v_q    <= 1'b0;
      byp_hit_q <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      if (s1_ready) begin
        s1_v_q <= req_valid_i;
      end
      if (pop) begin
        byp_hit_q <= s1_adv && (s1_col_q == req_col_i);
      end
      if (s2_ready) begin
        s2_v_q <= s1_v_q;
      end
      if (s3_ready) begin
        s3_v_q <= s2_v_q;
      end
      if (s1_adv) begin
        for (int i = 0; i < 6; i++) begin
          win_q[i] <= win_q[i + 3];
        end
        win_q[6] <= up_s1;
        win_q[7] <= mid_s1;
        win_q[8] <= cur_s1;
      end
    end
  end

  // rows of three: columns (l, m, r) picked by edge replication
  always_comb begin
    pix_t al, am, ar, bl, bm;
    for (int k = 0; k < 3; k++) begin
      al = s2_flags_q.a_edge ? win_q[3 + k] : win_q[k];
      am = win_q[3 + k];
      ar = win_q[6 + k];
      bl = s2_flags_q.b_single ? win_q[6 + k] : win_q[3 + k];
      bm = win_q[6 + k];
      a_min_d[k] = min2(min2(al, am), ar);
      a_max_d[k] = max2(max2(al, am), ar);
      a_med_d[k] = med3(al, am, ar);
      b_min_d[k] = min2(min2(bl, bm), bm);
      b_max_d[k] = max2(max2(bl, bm), bm);
      b_med_d[k] = med3(bl, bm, bm);
    end
  end

  assign med_a = med3(max2(max2(a_min_q[0], a_min_q[1]), a_min_q[2]),
                      med3(a_med_q[0], a_med_q[1], a_med_q[2]),
                      min2(min2(a_max_q[0], a_max_q[1]), a_max_q[2]));
  assign med_b = med3(max2(max2(b_min_q[0], b_min_q[1]), b_min_q[2]),
                      med3(b_med_q[0], b_med_q[1], b_med_q[2]),
                      min2(min2(b_max_q[0], b_max_q[1]), b_max_q[2]));

  always_ff @(posedge clk_i) begin
    if (pend_v_q && (out_take || !out_v_q)) begin
      out_med_q       <= pend_med_q;
      out_row_end_q   <= 1'b1;
      out_frame_end_q <= pend_frame_end_q;
    end else if (s3_adv && s3_flags_q.has_a) begin
      out_med_q        <= med_a;
      out_row_end_q    <= 1'b0;
      out_frame_end_q  <= 1'b0;
      pend_med_q       <= med_b;
      pend_frame_end_q <= s3_flags_q.last_row;
    end else if (s3_adv && s3_flags_q.has_b) begin
      out_med_q       <= med_b;
      out_row_end_q   <= 1'b1;
      out_frame_end_q <= s3_flags_q.last_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      if (pend_v_q && (out_take || !out_v_q)) begin
        out_v_q  <= 1'b1;
        pend_v_q <= 1'b0;
      end else if (s3_adv && (s3_flags_q.has_a || s3_flags_q.has_b)) begin
        out_v_q  <= 1'b1;
        pend_v_q <= s3_flags_q.has_a && s3_flags_q.has_b;
      end else if (out_take) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_v_q;
  assign median_out_o = out_med_q;
  assign row_end_o    = out_row_end_q;
  assign frame_end_o  = out_frame_end_q;

  `ASSERT_IMPLIES(a_pend_behind_out, clk_i, rst_ni, pend_v_q, out_v_q, "pending result without output")
  `ASSERT_NEXT(a_pend_is_row_end, clk_i, rst_ni, pend_v_q && out_take, out_v_q && out_row_end_q, "row-end result lost")

endmodule

>>> hdl/median_3x3_filter.sv
// Top level of the streaming 3x3 median filter.
//
// Streaming 3x3 median filter. Pixels enter in raster order, one request per
// clock while in_ready_o is high, and each output is the median of the
// pixel's 3x3 neighbourhood, with the frame's edge pixels replicated outward
// on all four sides. Results lag the input by one row: input row r produces
// output row r-1, column c-1 comes out while column c goes in, and the last
// column's request also produces the row's final pixel (row_end set,
// frame_end also set on the frame's last row). After the last pixel row,
// drive one row of flush requests (func = 1, pixel ignored) to push out the
// final output row; the position then wraps to the next frame. Sustained
// rate is one request per clock while out_ready_i stays high; the back end
// pauses only at the output at the end of each output row, where one
// request yields two results (one-pixel-wide frames give at most one result
// per request and keep the full rate). A request passes the queue, line
// store read, window, row sort and final median registers. Two line
// stores of MAX_WIDTH samples hold the previous two rows; their contents
// are undefined after reset and need no clearing pass, as the first row of
// a frame overwrites them before they are used. Write image_width (index 0)
// and image_height (index 1) only while no request is in flight; a write
// restarts the frame at row 0, column 0. Zero is taken as 1, and values
// above MAX_WIDTH or 4096 are taken as those maxima.
module median_3x3_filter #(
  parameter int MAX_WIDTH  = 4096,
  parameter int PIXEL_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mf3_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  logic [mf3_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                func_i,
  input  logic [PIXEL_BITS-1:0]               pixel_in_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [PIXEL_BITS-1:0]               median_out_o,
  output logic                                row_end_o,
  output logic                                frame_end_o
);

  import mf3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int QW = CW + PIXEL_BITS + FLAGS_BITS;

  // register writes always land at once
  assign cfg_ready_o = 1'b1;

  logic          q_ready, push, q_valid, pop;
  mf3_flags_t    front_flags, back_flags;
  logic [CW-1:0] front_col, back_col;
  logic [PIXEL_BITS-1:0] back_pixel;
  logic [QW-1:0] q_wdata, q_rdata;

  // front: position tracking and classification of each request
  mf3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .func_i      (func_i),
    .q_ready_i   (q_ready),
    .in_ready_o  (in_ready_o),
    .push_o      (push),
    .flags_o     (front_flags),
    .col_o       (front_col)
  );

  assign q_wdata = {front_col, pixel_in_i, front_flags};

  // decouples the front from back-end stalls at the output
  mf3_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_wdata),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .pop_i   (pop),
    .data_o  (q_rdata)
  );

  assign back_flags = mf3_flags_t'(q_rdata[FLAGS_BITS-1:0]);
  assign back_pixel = q_rdata[FLAGS_BITS +: PIXEL_BITS];
  assign back_col   = q_rdata[FLAGS_BITS + PIXEL_BITS +: CW];

  logic back_ready;
  assign pop = q_valid && back_ready;

  // back: line stores, window and compare network
  mf3_back #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (q_valid),
    .req_ready_o  (back_ready),
    .req_flags_i  (back_flags),
    .req_col_i    (back_col),
    .req_pixel_i  (back_pixel),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .median_out_o (median_out_o),
    .row_end_o    (row_end_o),
    .frame_end_o  (frame_end_o)
  );

endmodule
